// ----- src/evmjv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evmjv_pkg
// Shared types, codes and widths of the jump validation unit.
// ----------------------------------------------------------------------------
package evmjv_pkg;

  // field widths
  localparam int CMD_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int PC_W     = 15;
  localparam int GAS_W    = 63;
  localparam int DEPTH_W  = 11;
  localparam int DEST_W   = 64;
  localparam int STATUS_W = 3;
  localparam int NPC_W    = 16;
  localparam int POPS_W   = 2;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PEND_W   = 6;

  // default code capacity in bytes
  localparam int MAX_CODE_BYTES_DEF = 32768;

  // request commands
  localparam logic [CMD_W-1:0] CMD_START    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_JUMP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_JUMPI    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_JUMPDEST = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOG       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_DEST  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_COST     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMPI_COST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMPDEST_COST = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] JUMP_COST_RST     = 16'd8;
  localparam logic [CFG_W-1:0] JUMPI_COST_RST    = 16'd10;
  localparam logic [CFG_W-1:0] JUMPDEST_COST_RST = 16'd1;

  // opcode bytes
  localparam logic [BYTE_W-1:0] JDEST_BYTE      = 8'h5B;
  localparam logic [BYTE_W-1:0] PUSH_FIRST_BYTE = 8'h60;
  localparam logic [BYTE_W-1:0] PUSH_LAST_BYTE  = 8'h7F;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic check;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic needs_check;
  } dp_stat_t;

endpackage

// ----- src/evm_jump_validation_unit.sv -----
`timescale 1ns / 1ps
// Start and load requests pass the request capture, the execute state and the
// result registers; jump, conditional jump and jumpdest requests also pass the
// check state, which adds the registered read of the destination mark memory.
// A new request is taken only while the controller is idle, not while busy.
// Synchronous active-low reset restores the default costs, empties the code
// and clears the result strobe; results are not held off by the receiver.
// ----------------------------------------------------------------------------
// evm_jump_validation_unit
// Loads contract code, marks valid jump destinations and checks jumps.
// ----------------------------------------------------------------------------
module evm_jump_validation_unit #(
  parameter int MAX_CODE_BYTES = evmjv_pkg::MAX_CODE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [evmjv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [evmjv_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                              start,
  output logic                              busy,
  input  logic [evmjv_pkg::CMD_W-1:0]       in_command,
  input  logic [evmjv_pkg::BYTE_W-1:0]      in_code_byte,
  input  logic [evmjv_pkg::PC_W-1:0]        in_pc,
  input  logic [evmjv_pkg::GAS_W-1:0]       in_gas_left,
  input  logic [evmjv_pkg::DEPTH_W-1:0]     in_stack_depth,
  input  logic [evmjv_pkg::DEST_W-1:0]      in_dest,
  input  logic                              in_cond_nonzero,
  output logic                              out_valid,
  output logic [evmjv_pkg::STATUS_W-1:0]    out_status,
  output logic                              out_taken,
  output logic [evmjv_pkg::NPC_W-1:0]       out_next_pc,
  output logic [evmjv_pkg::GAS_W-1:0]       out_gas_after,
  output logic [evmjv_pkg::POPS_W-1:0]      out_pops
);

  evmjv_pkg::ctrl_cmd_t cmd;
  evmjv_pkg::dp_stat_t  stat;

  // request sequencing
  evmjv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // code state, checks and results
  evmjv_datapath #(
    .MAX_CODE_BYTES (MAX_CODE_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_command),
    .in_code_byte    (in_code_byte),
    .in_pc           (in_pc),
    .in_gas_left     (in_gas_left),
    .in_stack_depth  (in_stack_depth),
    .in_dest         (in_dest),
    .in_cond_nonzero (in_cond_nonzero),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_taken       (out_taken),
    .out_next_pc     (out_next_pc),
    .out_gas_after   (out_gas_after),
    .out_pops        (out_pops)
  );

endmodule

// ----- src/evmjv_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evmjv_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module evmjv_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/evmjv_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evmjv_ctrl
// Controller: sequences capture, execute and mark check of one request.
// ----------------------------------------------------------------------------
module evmjv_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  evmjv_pkg::dp_stat_t  stat,
  output evmjv_pkg::ctrl_cmd_t cmd,
  output logic                 busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = stat.needs_check ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath commands
  assign cmd.capture = (state_r == S_IDLE) && start;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.check   = (state_r == S_CHECK);
  assign busy        = (state_r != S_IDLE);

endmodule

// ----- src/evmjv_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evmjv_datapath
// Request registers, cost registers, code state, mark memory and results.
// ----------------------------------------------------------------------------
module evmjv_datapath #(
  parameter int MAX_CODE_BYTES = evmjv_pkg::MAX_CODE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  evmjv_pkg::ctrl_cmd_t              cmd,
  output evmjv_pkg::dp_stat_t               stat,
  input  logic                              cfg_we,
  input  logic [evmjv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [evmjv_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic [evmjv_pkg::CMD_W-1:0]       in_command,
  input  logic [evmjv_pkg::BYTE_W-1:0]      in_code_byte,
  input  logic [evmjv_pkg::PC_W-1:0]        in_pc,
  input  logic [evmjv_pkg::GAS_W-1:0]       in_gas_left,
  input  logic [evmjv_pkg::DEPTH_W-1:0]     in_stack_depth,
  input  logic [evmjv_pkg::DEST_W-1:0]      in_dest,
  input  logic                              in_cond_nonzero,
  output logic                              out_valid,
  output logic [evmjv_pkg::STATUS_W-1:0]    out_status,
  output logic                              out_taken,
  output logic [evmjv_pkg::NPC_W-1:0]       out_next_pc,
  output logic [evmjv_pkg::GAS_W-1:0]       out_gas_after,
  output logic [evmjv_pkg::POPS_W-1:0]      out_pops
);

  localparam int AW = $clog2(MAX_CODE_BYTES);
  localparam int LW = $clog2(MAX_CODE_BYTES + 1);
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_CODE_BYTES);

  // captured request
  logic [evmjv_pkg::CMD_W-1:0]   cmd_r;
  logic [evmjv_pkg::BYTE_W-1:0]  byte_r;
  logic [evmjv_pkg::PC_W-1:0]    pc_r;
  logic [evmjv_pkg::GAS_W-1:0]   gas_r;
  logic [evmjv_pkg::DEPTH_W-1:0] depth_r;
  logic [evmjv_pkg::DEST_W-1:0]  dest_r;
  logic                          cond_r;

  // cost registers
  logic [evmjv_pkg::CFG_W-1:0] jump_cost_r;
  logic [evmjv_pkg::CFG_W-1:0] jumpi_cost_r;
  logic [evmjv_pkg::CFG_W-1:0] jumpdest_cost_r;

  // code state
  logic [LW-1:0]                code_len_r;
  logic [LW-1:0]                code_len_nxt;
  logic [evmjv_pkg::PEND_W-1:0] pend_r;
  logic [evmjv_pkg::PEND_W-1:0] pend_nxt;

  // gas charge, registered between execute and check
  logic [evmjv_pkg::GAS_W-1:0] gas_diff_r;
  logic                        oog_r;
  logic [evmjv_pkg::CFG_W-1:0] cost;
  logic [evmjv_pkg::GAS_W:0]   gas_diff;

  // mark memory signals
  logic          mark_we;
  logic          mark_wdata;
  logic          mark_rdata;
  logic          code_full;
  logic          is_push;

  // result signals
  logic                            res_valid;
  logic [evmjv_pkg::STATUS_W-1:0]  res_status;
  logic                            res_taken;
  logic [evmjv_pkg::NPC_W-1:0]     res_next_pc;
  logic [evmjv_pkg::GAS_W-1:0]     res_gas;
  logic [evmjv_pkg::POPS_W-1:0]    res_pops;
  logic [evmjv_pkg::NPC_W-1:0]     pc_inc;
  logic [evmjv_pkg::POPS_W-1:0]    need;
  logic                            dest_in_range;

  logic                            out_valid_r;
  logic [evmjv_pkg::STATUS_W-1:0]  out_status_r;
  logic                            out_taken_r;
  logic [evmjv_pkg::NPC_W-1:0]     out_next_pc_r;
  logic [evmjv_pkg::GAS_W-1:0]     out_gas_r;
  logic [evmjv_pkg::POPS_W-1:0]    out_pops_r;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_command;
      byte_r  <= in_code_byte;
      pc_r    <= in_pc;
      gas_r   <= in_gas_left;
      depth_r <= in_stack_depth;
      dest_r  <= in_dest;
      cond_r  <= in_cond_nonzero;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_cost_r     <= evmjv_pkg::JUMP_COST_RST;
      jumpi_cost_r    <= evmjv_pkg::JUMPI_COST_RST;
      jumpdest_cost_r <= evmjv_pkg::JUMPDEST_COST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        evmjv_pkg::CFG_JUMP_COST:     jump_cost_r     <= cfg_wdata;
        evmjv_pkg::CFG_JUMPI_COST:    jumpi_cost_r    <= cfg_wdata;
        evmjv_pkg::CFG_JUMPDEST_COST: jumpdest_cost_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // jump class requests need the mark check state
  assign stat.needs_check = (cmd_r == evmjv_pkg::CMD_JUMP) ||
                            (cmd_r == evmjv_pkg::CMD_JUMPI) ||
                            (cmd_r == evmjv_pkg::CMD_JUMPDEST);

  // code loading: mark and push immediate tracking
  assign code_full  = (code_len_r == MAX_LEN);
  assign is_push    = (byte_r >= evmjv_pkg::PUSH_FIRST_BYTE) &&
                      (byte_r <= evmjv_pkg::PUSH_LAST_BYTE);
  assign mark_wdata = (pend_r == '0) && (byte_r == evmjv_pkg::JDEST_BYTE);
  assign mark_we    = cmd.exec && (cmd_r == evmjv_pkg::CMD_LOAD) && !code_full;

  always_comb begin
    code_len_nxt = code_len_r;
    pend_nxt     = pend_r;
    if (cmd.exec && (cmd_r == evmjv_pkg::CMD_START)) begin
      code_len_nxt = '0;
      pend_nxt     = '0;
    end else if (mark_we) begin
      code_len_nxt = code_len_r + LW'(1);
      if (pend_r != '0) begin
        pend_nxt = pend_r - evmjv_pkg::PEND_W'(1);
      end else if (is_push) begin
        pend_nxt = {1'b0, byte_r[4:0]} + evmjv_pkg::PEND_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_len_r <= '0;
      pend_r     <= '0;
    end else begin
      code_len_r <= code_len_nxt;
      pend_r     <= pend_nxt;
    end
  end

  // jump destination marks
  evmjv_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CODE_BYTES)
  ) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (code_len_r[AW-1:0]),
    .wdata (mark_wdata),
    .raddr (dest_r[AW-1:0]),
    .rdata (mark_rdata)
  );

  // gas charge
  always_comb begin
    case (cmd_r)
      evmjv_pkg::CMD_JUMP:  cost = jump_cost_r;
      evmjv_pkg::CMD_JUMPI: cost = jumpi_cost_r;
      default:              cost = jumpdest_cost_r;
    endcase
  end

  assign gas_diff = {1'b0, gas_r} - {{(evmjv_pkg::GAS_W + 1 - evmjv_pkg::CFG_W){1'b0}}, cost};

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      gas_diff_r <= gas_diff[evmjv_pkg::GAS_W-1:0];
      oog_r      <= gas_diff[evmjv_pkg::GAS_W];
    end
  end

  // result assembly
  assign pc_inc        = {1'b0, pc_r} + evmjv_pkg::NPC_W'(1);
  assign dest_in_range = (dest_r[evmjv_pkg::DEST_W-1:LW] == '0) &&
                         (dest_r[LW-1:0] < code_len_r);

  always_comb begin
    case (cmd_r)
      evmjv_pkg::CMD_JUMP:  need = evmjv_pkg::POPS_W'(1);
      evmjv_pkg::CMD_JUMPI: need = evmjv_pkg::POPS_W'(2);
      default:              need = '0;
    endcase
  end

  always_comb begin
    res_valid   = 1'b0;
    res_status  = evmjv_pkg::ST_OK;
    res_taken   = 1'b0;
    res_next_pc = '0;
    res_gas     = '0;
    res_pops    = '0;
    if (cmd.exec && !stat.needs_check) begin
      // start, load and unknown requests finish here
      res_valid = 1'b1;
      if ((cmd_r == evmjv_pkg::CMD_LOAD) && code_full) begin
        res_status = evmjv_pkg::ST_FULL;
      end
    end else if (cmd.check) begin
      res_valid   = 1'b1;
      res_next_pc = pc_inc;
      if (oog_r) begin
        res_status = evmjv_pkg::ST_OOG;
      end else if (depth_r < {{(evmjv_pkg::DEPTH_W - evmjv_pkg::POPS_W){1'b0}}, need}) begin
        res_status = evmjv_pkg::ST_UNDERFLOW;
      end else begin
        res_gas  = gas_diff_r;
        res_pops = need;
        if ((cmd_r == evmjv_pkg::CMD_JUMP) || ((cmd_r == evmjv_pkg::CMD_JUMPI) && cond_r)) begin
          if (!dest_in_range || !mark_rdata) begin
            res_status = evmjv_pkg::ST_BAD_DEST;
            res_gas    = '0;
          end else begin
            res_taken   = 1'b1;
            res_next_pc = dest_r[evmjv_pkg::NPC_W-1:0];
          end
        end
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_status_r  <= res_status;
      out_taken_r   <= res_taken;
      out_next_pc_r <= res_next_pc;
      out_gas_r     <= res_gas;
      out_pops_r    <= res_pops;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_taken     = out_taken_r;
  assign out_next_pc   = out_next_pc_r;
  assign out_gas_after = out_gas_r;
  assign out_pops      = out_pops_r;

endmodule
